// ===== sv/ihmc_pkg.sv =====
// ----------------------------------------------------------------------------
// ihmc_pkg
// Types, constants and register map shared by the IP header mesh destination
// classifier and its verdict logic.
// ----------------------------------------------------------------------------
package ihmc_pkg;

  // Only the first MAX_PACKET_BYTES bytes of a packet count as usable.
  localparam logic [15:0] MAX_PACKET_BYTES = 16'd2048;
  localparam logic [15:0] BYTE_COUNT_MAX   = 16'hffff;

  localparam logic [3:0] VERSION_V4 = 4'd4;
  localparam logic [3:0] VERSION_V6 = 4'd6;

  localparam logic [15:0] MIN_LEN_V4     = 16'd20;
  localparam logic [15:0] MIN_LEN_V6     = 16'd40;
  localparam logic [16:0] V6_HEADER_LEN  = 17'd40;

  // Mesh address prefixes.
  localparam logic [7:0] V4_MESH_A      = 8'd10;
  localparam logic [7:0] V4_MESH_B0     = 8'd192;
  localparam logic [7:0] V4_MESH_B1     = 8'd168;
  localparam logic [7:0] V6_MESH_A      = 8'h02;
  localparam logic [7:0] V6_MESH_B      = 8'h03;
  localparam logic [7:0] V6_LINK_B0     = 8'hfe;
  localparam logic [7:0] V6_LINK_B1     = 8'h80;
  localparam logic [3:0] V4_MCAST_NIB   = 4'he;
  localparam logic [7:0] V6_MCAST_BYTE  = 8'hff;

  // Register indexes (byte address 4*i).
  localparam logic [1:0] REG_GATEWAY_ID    = 2'd0;
  localparam logic [1:0] REG_GATEWAY_VALID = 2'd1;
  localparam logic [1:0] REG_ENABLE_V4     = 2'd2;
  localparam logic [1:0] REG_ENABLE_V6     = 2'd3;

  typedef enum logic [2:0] {
    VERDICT_FORWARD   = 3'd0,
    VERDICT_DISABLED  = 3'd1,
    VERDICT_SHORT     = 3'd2,
    VERDICT_MULTICAST = 3'd3,
    VERDICT_NO_DEST   = 3'd4,
    VERDICT_FOREIGN   = 3'd5,
    VERDICT_TRUNCATED = 3'd6
  } verdict_t;

  typedef struct packed {
    logic [31:0] gw_node;
    logic        gateway_valid;
    logic        enable_v4;
    logic        enable_v6;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  version_nib;
    logic [15:0] declared_length;
    logic [15:0] source_prefix;
    logic [31:0] source_tail;
    logic [15:0] dest_prefix;
    logic [31:0] dest_tail;
  } pkt_state_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [31:0] dest_node;
    logic [15:0] packet_bytes;
  } result_t;

endpackage

// ===== sv/ip_header_mesh_id_classifier_core.sv =====
// ----------------------------------------------------------------------------
// ip_header_mesh_id_classifier_core
// Classifies IPv4/IPv6 packets arriving one byte per transfer and gives a
// verdict and destination node id on the last byte of each packet.
//
//   port group  direction  carries
//   in_*        input      one packet byte and a last-byte flag per transfer
//   out_*       output     verdict, node id and byte count, once per packet
//   p*          APB        gateway id/valid and per-version enables
//
// A byte is taken in every cycle that the result queue is not full; header fields are captured as bytes are
// transferred and the verdict is registered in the cycle after the last byte.
// A two-entry result queue lets input continue while a result waits, so input
// stalls only when both entries are full. Reset is synchronous and clears the
// packet state, the queue and the registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ip_header_mesh_id_classifier_core (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_verdict,
  output logic [31:0] out_dest_node,
  output logic [15:0] out_packet_bytes,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ihmc_pkg::*;

  // Configuration registers
  cfg_t        cfg_r;
  logic        cfg_we;
  logic [1:0]  reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_we    = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gw_node       <= 32'd0;
      cfg_r.gateway_valid <= 1'b0;
      cfg_r.enable_v4     <= 1'b1;
      cfg_r.enable_v6     <= 1'b1;
    end else if (cfg_we) begin
      case (reg_index)
        REG_GATEWAY_ID:    cfg_r.gw_node       <= pwdata;
        REG_GATEWAY_VALID: cfg_r.gateway_valid <= pwdata[0];
        REG_ENABLE_V4:     cfg_r.enable_v4     <= pwdata[0];
        REG_ENABLE_V6:     cfg_r.enable_v6     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_GATEWAY_ID:    prdata = cfg_r.gw_node;
      REG_GATEWAY_VALID: prdata = {31'd0, cfg_r.gateway_valid};
      REG_ENABLE_V4:     prdata = {31'd0, cfg_r.enable_v4};
      REG_ENABLE_V6:     prdata = {31'd0, cfg_r.enable_v6};
      default:           prdata = 32'd0;
    endcase
  end

  // Per-byte header capture
  logic        in_fire;
  logic [15:0] byte_index_r;
  logic [15:0] byte_index_nxt;
  pkt_state_t  pkt_r;
  pkt_state_t  pkt_cap;
  logic [15:0] count;
  logic [15:0] usable;
  logic [3:0]  version_eff;

  assign in_fire = in_valid && in_ready;
  assign count   = (byte_index_r < BYTE_COUNT_MAX) ? (byte_index_r + 16'd1)
                                                    : BYTE_COUNT_MAX;
  assign usable  = (count < MAX_PACKET_BYTES) ? count : MAX_PACKET_BYTES;

  // The version nibble arrives with the first byte and steers that same byte.
  assign version_eff = (byte_index_r == 16'd0) ? in_data_byte[7:4] : pkt_r.version_nib;

  always_comb begin
    pkt_cap = pkt_r;
    if (byte_index_r < MAX_PACKET_BYTES) begin
      pkt_cap.version_nib = version_eff;
      if (version_eff == VERSION_V4) begin
        if (byte_index_r == 16'd2 || byte_index_r == 16'd3)
          pkt_cap.declared_length = {pkt_r.declared_length[7:0], in_data_byte};
        if (byte_index_r == 16'd12 || byte_index_r == 16'd13)
          pkt_cap.source_prefix = {pkt_r.source_prefix[7:0], in_data_byte};
        if (byte_index_r >= 16'd12 && byte_index_r <= 16'd15)
          pkt_cap.source_tail = {pkt_r.source_tail[23:0], in_data_byte};
        if (byte_index_r == 16'd16 || byte_index_r == 16'd17)
          pkt_cap.dest_prefix = {pkt_r.dest_prefix[7:0], in_data_byte};
        if (byte_index_r >= 16'd16 && byte_index_r <= 16'd19)
          pkt_cap.dest_tail = {pkt_r.dest_tail[23:0], in_data_byte};
      end else if (version_eff == VERSION_V6) begin
        if (byte_index_r == 16'd4 || byte_index_r == 16'd5)
          pkt_cap.declared_length = {pkt_r.declared_length[7:0], in_data_byte};
        if (byte_index_r == 16'd8 || byte_index_r == 16'd9)
          pkt_cap.source_prefix = {pkt_r.source_prefix[7:0], in_data_byte};
        if (byte_index_r >= 16'd20 && byte_index_r <= 16'd23)
          pkt_cap.source_tail = {pkt_r.source_tail[23:0], in_data_byte};
        if (byte_index_r == 16'd24 || byte_index_r == 16'd25)
          pkt_cap.dest_prefix = {pkt_r.dest_prefix[7:0], in_data_byte};
        if (byte_index_r >= 16'd36 && byte_index_r <= 16'd39)
          pkt_cap.dest_tail = {pkt_r.dest_tail[23:0], in_data_byte};
      end
    end
  end

  assign byte_index_nxt = in_last_byte ? 16'd0 : count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r <= 16'd0;
      pkt_r        <= '0;
    end else if (in_fire) begin
      byte_index_r <= byte_index_nxt;
      pkt_r        <= in_last_byte ? pkt_state_t'('0) : pkt_cap;
    end
  end

  // Verdict
  verdict_t    verdict;
  logic [31:0] dest_node;
  result_t     new_result;

  ihmc_classify u_classify (
    .pkt       (pkt_cap),
    .cfg       (cfg_r),
    .usable    (usable),
    .verdict   (verdict),
    .dest_node (dest_node)
  );

  assign new_result.verdict      = verdict;
  assign new_result.dest_node    = dest_node;
  assign new_result.packet_bytes = count;

  // Two-entry result queue: head drives the outputs, skid catches a result
  // that completes while the head is still waiting.
  logic    push;
  logic    pop;
  logic    head_valid_r;
  logic    head_valid_nxt;
  logic    skid_valid_r;
  logic    skid_valid_nxt;
  result_t head_r;
  result_t head_nxt;
  result_t skid_r;
  result_t skid_nxt;

  assign in_ready = !skid_valid_r;
  assign push     = in_fire && in_last_byte;
  assign pop      = head_valid_r && out_ready;

  always_comb begin
    head_valid_nxt = head_valid_r;
    skid_valid_nxt = skid_valid_r;
    head_nxt       = head_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (pop) begin
        head_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (head_valid_r && !pop) begin
        skid_nxt       = new_result;
        skid_valid_nxt = 1'b1;
      end else begin
        head_nxt       = new_result;
        head_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      head_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      head_valid_r <= head_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid        = head_valid_r;
  assign out_verdict      = head_r.verdict;
  assign out_dest_node    = head_r.dest_node;
  assign out_packet_bytes = head_r.packet_bytes;

endmodule

// ===== sv/ihmc_classify.sv =====
// ----------------------------------------------------------------------------
// ihmc_classify
// Verdict logic: turns the captured header fields of a finished packet and the
// configuration into a verdict and a destination node id.
// ----------------------------------------------------------------------------
module ihmc_classify (
  input  ihmc_pkg::pkt_state_t pkt,
  input  ihmc_pkg::cfg_t       cfg,
  input  logic [15:0]          usable,
  output ihmc_pkg::verdict_t   verdict,
  output logic [31:0]          dest_node
);
  import ihmc_pkg::*;

  function automatic logic v4_mesh(input logic [15:0] prefix);
    v4_mesh = (prefix[15:8] == V4_MESH_A) ||
              ((prefix[15:8] == V4_MESH_B0) && (prefix[7:0] == V4_MESH_B1));
  endfunction

  function automatic logic v6_mesh(input logic [15:0] prefix);
    v6_mesh = (prefix[15:8] == V6_MESH_A) || (prefix[15:8] == V6_MESH_B) ||
              ((prefix[15:8] == V6_LINK_B0) && (prefix[7:0] == V6_LINK_B1));
  endfunction

  logic        is_v4;
  logic        is_v6;
  logic        enabled;
  logic        too_short;
  logic        mcast;
  logic        dst_mesh;
  logic        src_mesh;
  logic [16:0] need;
  logic [31:0] mesh_id;

  assign is_v4   = (pkt.version_nib == VERSION_V4);
  assign is_v6   = (pkt.version_nib == VERSION_V6);
  assign enabled = (is_v4 && cfg.enable_v4) || (is_v6 && cfg.enable_v6);

  assign too_short = is_v6 ? (usable < MIN_LEN_V6) : (usable < MIN_LEN_V4);
  assign mcast     = is_v6 ? (pkt.dest_prefix[15:8] == V6_MCAST_BYTE)
                           : (pkt.dest_prefix[15:12] == V4_MCAST_NIB);
  assign dst_mesh  = is_v6 ? v6_mesh(pkt.dest_prefix) : v4_mesh(pkt.dest_prefix);
  assign src_mesh  = is_v6 ? v6_mesh(pkt.source_prefix) : v4_mesh(pkt.source_prefix);

  // IPv6 carries a payload length, so the fixed header is added back on.
  assign need    = is_v6 ? (V6_HEADER_LEN + {1'b0, pkt.declared_length})
                         : {1'b0, pkt.declared_length};
  assign mesh_id = is_v6 ? pkt.dest_tail : {8'd0, pkt.dest_tail[23:0]};

  always_comb begin
    verdict   = VERDICT_FORWARD;
    dest_node = 32'd0;
    if (!enabled) begin
      verdict = VERDICT_DISABLED;
    end else if (too_short) begin
      verdict = VERDICT_SHORT;
    end else if (mcast) begin
      verdict = VERDICT_MULTICAST;
    end else if (!dst_mesh && !cfg.gateway_valid) begin
      verdict = VERDICT_NO_DEST;
    end else if (!src_mesh) begin
      verdict = VERDICT_FOREIGN;
    end else if ({1'b0, usable} < need) begin
      verdict = VERDICT_TRUNCATED;
    end else begin
      dest_node = dst_mesh ? mesh_id : cfg.gw_node;
    end
  end

endmodule

// ===== tb/ip_header_mesh_id_classifier_core_tb.sv =====
// ----------------------------------------------------------------------------
// ip_header_mesh_id_classifier_core_tb
// Self-checking bench for the IP header mesh destination classifier. Packets
// are sent one byte per transfer, and a scoreboard keeps its own copy of the
// classification rules. Each verdict, node id and byte count the block
// returns is compared with the expected one, across several register
// settings, with random gaps on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module ip_header_mesh_id_classifier_core_tb;
  import ihmc_pkg::*;

  localparam int QUIET_LIMIT            = 2000;
  localparam int HOLD_CYCLES            = 400;
  localparam int RANDOM_BYTES_PER_PHASE = 90;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } wire_byte_t;

  typedef enum int {ADDR_MESH, ADDR_OTHER, ADDR_MCAST} addr_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_verdict;
  logic [31:0] out_dest_node;
  logic [15:0] out_packet_bytes;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ip_header_mesh_id_classifier_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_verdict      (out_verdict),
    .out_dest_node    (out_dest_node),
    .out_packet_bytes (out_packet_bytes),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  wire_byte_t  bytes_to_send[$];
  result_t     expected_verdicts[$];
  logic [7:0]  pkt_buf[];

  // Register copies used by the classifier model.
  logic [31:0] cfg_gw_id = '0;
  logic        cfg_gw_valid = 1'b0;
  logic        cfg_v4_on = 1'b1;
  logic        cfg_v6_on = 1'b1;

  // Per-packet capture state of the model.
  logic [15:0] p_count = '0;
  logic [3:0]  p_ver = '0;
  logic [15:0] p_decl = '0;
  logic [15:0] p_src_pfx = '0;
  logic [31:0] p_src_tail = '0;
  logic [15:0] p_dst_pfx = '0;
  logic [31:0] p_dst_tail = '0;

  logic        tx_idle_on = 1'b1;
  logic        rx_idle_on = 1'b1;
  int          tx_gap = 0;
  int          rx_wait = 0;
  int          rx_hold = 0;
  int          rx_draw;
  int          hold_requests = 0;
  int          hold_served = 0;
  int          quiet_cycles = 0;
  wire_byte_t  tx_next;
  result_t     want;

  int unsigned mismatch_count = 0;
  int unsigned bytes_queued = 0;
  int unsigned bytes_taken = 0;
  int unsigned results_checked = 0;
  int unsigned settings_applied = 0;
  int unsigned verdict_tally[7];

  function automatic logic mesh_v4(input logic [15:0] pfx);
    return pfx[15:8] == V4_MESH_A || pfx == {V4_MESH_B0, V4_MESH_B1};
  endfunction

  function automatic logic mesh_v6(input logic [15:0] pfx);
    return pfx[15:8] == V6_MESH_A || pfx[15:8] == V6_MESH_B ||
           pfx == {V6_LINK_B0, V6_LINK_B1};
  endfunction

  task automatic capture_byte(input logic [15:0] idx, input logic [7:0] b);
    if (idx == 16'd0) p_ver = b[7:4];
    if (p_ver == VERSION_V4) begin
      if (idx == 16'd2 || idx == 16'd3) p_decl = {p_decl[7:0], b};
      if (idx == 16'd12 || idx == 16'd13) p_src_pfx = {p_src_pfx[7:0], b};
      if (idx >= 16'd12 && idx <= 16'd15) p_src_tail = {p_src_tail[23:0], b};
      if (idx == 16'd16 || idx == 16'd17) p_dst_pfx = {p_dst_pfx[7:0], b};
      if (idx >= 16'd16 && idx <= 16'd19) p_dst_tail = {p_dst_tail[23:0], b};
    end else if (p_ver == VERSION_V6) begin
      if (idx == 16'd4 || idx == 16'd5) p_decl = {p_decl[7:0], b};
      if (idx == 16'd8 || idx == 16'd9) p_src_pfx = {p_src_pfx[7:0], b};
      if (idx >= 16'd20 && idx <= 16'd23) p_src_tail = {p_src_tail[23:0], b};
      if (idx == 16'd24 || idx == 16'd25) p_dst_pfx = {p_dst_pfx[7:0], b};
      if (idx >= 16'd36 && idx <= 16'd39) p_dst_tail = {p_dst_tail[23:0], b};
    end
  endtask

  // Takes one accepted byte; on the last byte of a packet the verdict it
  // should produce is queued.
  task automatic predict_verdict(input logic [7:0] b, input logic last);
    logic [15:0] idx;
    logic [15:0] usable;
    logic [16:0] need;
    logic        v6;
    logic        dmesh;
    logic        smesh;
    result_t     r;
    idx = p_count;
    if (idx < MAX_PACKET_BYTES) capture_byte(idx, b);
    p_count = (idx != BYTE_COUNT_MAX) ? idx + 16'd1 : BYTE_COUNT_MAX;
    if (last) begin
      usable = (p_count < MAX_PACKET_BYTES) ? p_count : MAX_PACKET_BYTES;
      v6 = (p_ver == VERSION_V6);
      dmesh = v6 ? mesh_v6(p_dst_pfx) : mesh_v4(p_dst_pfx);
      smesh = v6 ? mesh_v6(p_src_pfx) : mesh_v4(p_src_pfx);
      need = v6 ? V6_HEADER_LEN + {1'b0, p_decl} : {1'b0, p_decl};
      r.dest_node = '0;
      r.packet_bytes = p_count;
      if (!((p_ver == VERSION_V4 && cfg_v4_on) || (v6 && cfg_v6_on)))
        r.verdict = VERDICT_DISABLED;
      else if (usable < (v6 ? MIN_LEN_V6 : MIN_LEN_V4))
        r.verdict = VERDICT_SHORT;
      else if (v6 ? p_dst_pfx[15:8] == V6_MCAST_BYTE : p_dst_pfx[15:12] == V4_MCAST_NIB)
        r.verdict = VERDICT_MULTICAST;
      else if (!dmesh && !cfg_gw_valid)
        r.verdict = VERDICT_NO_DEST;
      else if (!smesh)
        r.verdict = VERDICT_FOREIGN;
      else if ({1'b0, usable} < need)
        r.verdict = VERDICT_TRUNCATED;
      else begin
        r.verdict = VERDICT_FORWARD;
        if (!dmesh) r.dest_node = cfg_gw_id;
        else if (v6) r.dest_node = p_dst_tail;
        else r.dest_node = {8'h00, p_dst_tail[23:0]};
      end
      expected_verdicts.push_back(r);
      p_count = '0;
      p_ver = '0;
      p_decl = '0;
      p_src_pfx = '0;
      p_src_tail = '0;
      p_dst_pfx = '0;
      p_dst_tail = '0;
    end
  endtask

  // Byte sender: a fresh gap is drawn for every byte it takes from the queue.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (tx_gap != 0) begin
        tx_gap <= tx_gap - 1;
        in_valid <= 1'b0;
      end else if (bytes_to_send.size() != 0) begin
        tx_next = bytes_to_send.pop_front();
        in_valid <= 1'b1;
        in_data_byte <= tx_next.data_byte;
        in_last_byte <= tx_next.last_byte;
        tx_gap <= tx_idle_on ? $urandom_range(0, 10) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver, with random stalls and the occasional long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait <= 0;
      rx_hold <= 0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      rx_hold <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      rx_draw = rx_idle_on ? $urandom_range(0, 10) : 0;
      rx_wait <= rx_draw;
      out_ready <= (rx_draw == 0);
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      out_ready <= (rx_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Scoreboard: the byte accepted at this edge is modelled first, then any
  // result transfer is compared with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_verdict(in_data_byte, in_last_byte);
        bytes_taken++;
      end
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          $error("unexpected result: verdict %0d, dest_node 0x%08h, packet_bytes %0d",
                 out_verdict, out_dest_node, out_packet_bytes);
          mismatch_count++;
        end else begin
          want = expected_verdicts.pop_front();
          if (out_verdict !== want.verdict) begin
            $error("verdict: expected %0d, got %0d", want.verdict, out_verdict);
            mismatch_count++;
          end
          if (out_dest_node !== want.dest_node) begin
            $error("dest_node: expected 0x%08h, got 0x%08h", want.dest_node, out_dest_node);
            mismatch_count++;
          end
          if (out_packet_bytes !== want.packet_bytes) begin
            $error("packet_bytes: expected %0d, got %0d", want.packet_bytes, out_packet_bytes);
            mismatch_count++;
          end
          verdict_tally[want.verdict]++;
          results_checked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $error("no transfer for %0d cycles", QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_GATEWAY_ID:    cfg_gw_id = val;
      REG_GATEWAY_VALID: cfg_gw_valid = val[0];
      REG_ENABLE_V4:     cfg_v4_on = val[0];
      REG_ENABLE_V6:     cfg_v6_on = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [31:0] gw, input logic gv,
                               input logic v4_on, input logic v6_on);
    write_reg(REG_GATEWAY_ID, gw);
    write_reg(REG_GATEWAY_VALID, {31'd0, gv});
    write_reg(REG_ENABLE_V4, {31'd0, v4_on});
    write_reg(REG_ENABLE_V6, {31'd0, v6_on});
    settings_applied++;
  endtask

  // Registers may only change once every byte has gone and every result is in.
  task automatic drain();
    do @(negedge clk);
    while (bytes_to_send.size() != 0 || in_valid || expected_verdicts.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_field(input int at, input int n, input logic [127:0] val);
    for (int i = 0; i < n; i++)
      if (at + i < pkt_buf.size()) pkt_buf[at + i] = val[8 * (n - 1 - i) +: 8];
  endtask

  // Builds a packet with the given version nibble and, for IPv4 and IPv6, the
  // length field and addresses in place; everything else is fill.
  task automatic queue_packet(input logic [3:0] ver, input int total, input int declared,
                              input logic [127:0] src, input logic [127:0] dst,
                              input int fill);
    pkt_buf = new[total];
    foreach (pkt_buf[i]) pkt_buf[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
    pkt_buf[0][7:4] = ver;
    if (ver == VERSION_V4) begin
      put_field(2, 2, 128'(declared));
      put_field(12, 4, {96'd0, src[31:0]});
      put_field(16, 4, {96'd0, dst[31:0]});
    end else if (ver == VERSION_V6) begin
      put_field(4, 2, 128'(declared));
      put_field(8, 16, src);
      put_field(24, 16, dst);
    end
    foreach (pkt_buf[i]) bytes_to_send.push_back('{pkt_buf[i], i == total - 1});
    bytes_queued += total;
  endtask

  function automatic logic [127:0] pick_addr(input logic v6, input addr_kind_t kind);
    logic [31:0]  a4;
    logic [127:0] a6;
    a4 = $urandom;
    a6 = {$urandom, $urandom, $urandom, $urandom};
    if (!v6) begin
      case (kind)
        ADDR_MESH:
          if ($urandom_range(0, 1) != 0) a4[31:24] = V4_MESH_A;
          else a4[31:16] = {V4_MESH_B0, V4_MESH_B1};
        ADDR_OTHER:
          while (mesh_v4(a4[31:16]) || a4[31:28] == V4_MCAST_NIB) a4 = $urandom;
        default: a4[31:28] = V4_MCAST_NIB;
      endcase
      return {96'd0, a4};
    end
    case (kind)
      ADDR_MESH:
        case ($urandom_range(0, 2))
          0: a6[127:120] = V6_MESH_A;
          1: a6[127:120] = V6_MESH_B;
          default: a6[127:112] = {V6_LINK_B0, V6_LINK_B1};
        endcase
      ADDR_OTHER:
        while (mesh_v6(a6[127:112]) || a6[127:120] == V6_MCAST_BYTE)
          a6[127:96] = $urandom;
      default: a6[127:120] = V6_MCAST_BYTE;
    endcase
    return a6;
  endfunction

  // Mostly well-formed headers with random content, the rest short or noise.
  task automatic queue_random_packet();
    int         total;
    int         declared;
    int         pick;
    logic       v6;
    logic [3:0] ver;
    addr_kind_t dkind;
    addr_kind_t skind;
    v6 = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 65) begin
      ver = v6 ? VERSION_V6 : VERSION_V4;
      total = v6 ? $urandom_range(40, 64) : $urandom_range(20, 48);
      if ($urandom_range(0, 9) == 0) total = v6 ? $urandom_range(1, 39) : $urandom_range(1, 19);
      declared = v6 ? total - 40 : total;
      case ($urandom_range(0, 9))
        0: declared += $urandom_range(1, 30);
        1: declared = $urandom_range(0, 65535);
        2: declared -= $urandom_range(1, 20);
        default: ;
      endcase
      if (declared < 0) declared = 0;
      pick = $urandom_range(0, 19);
      dkind = (pick < 14) ? ADDR_MESH : (pick < 17) ? ADDR_OTHER : ADDR_MCAST;
      skind = ($urandom_range(0, 9) < 8) ? ADDR_MESH : ADDR_OTHER;
    end else begin
      ver = 4'($urandom);
      v6 = (ver == VERSION_V6);
      total = $urandom_range(1, 24);
      declared = $urandom_range(0, 65535);
      dkind = addr_kind_t'($urandom_range(0, 2));
      skind = addr_kind_t'($urandom_range(0, 1));
    end
    queue_packet(ver, total, declared, pick_addr(v6, skind), pick_addr(v6, dkind), -1);
  endtask

  task automatic run_phase(input logic [31:0] gw, input logic gv, input logic v4_on,
                           input logic v6_on, input logic tx_idle, input logic rx_idle);
    int unsigned start;
    apply_setting(gw, gv, v4_on, v6_on);
    tx_idle_on = tx_idle;
    rx_idle_on = rx_idle;
    @(negedge clk);
    start = bytes_queued;
    while (bytes_queued - start < RANDOM_BYTES_PER_PHASE) queue_random_packet();
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed packets under the reset register values (no gateway).
    @(negedge clk);
    queue_packet(VERSION_V4, 20, 20, 128'h0a00_0001, 128'hc0a8_0102, 0);
    queue_packet(VERSION_V4, 20, 20, 128'hc0a8_ffff, 128'h0aff_ffff, 255);
    queue_packet(VERSION_V6, 40, 0, 128'hfe80_0000_0000_0000_0000_0000_0000_0001,
                 128'h0200_0000_0000_0000_0000_0000_dead_beef, -1);
    queue_packet(VERSION_V6, 41, 1, 128'h0300_0000_0000_0000_0000_0000_0000_0002,
                 128'h03ff_ffff_ffff_ffff_ffff_ffff_ffff_ffff, 255);
    queue_packet(VERSION_V6, 48, 8, 128'h0211_2233_4455_6677_8899_aabb_ccdd_eeff,
                 128'hfe80_0000_0000_0000_0000_0000_1234_5678, -1);
    // Versions other than 4 and 6, a one-byte packet among them.
    queue_packet(4'h0, 1, 0, '0, '0, 0);
    queue_packet(4'hf, 30, 0, '0, '0, 255);
    // Too short for the header of the version.
    queue_packet(VERSION_V4, 19, 19, 128'h0a00_0001, 128'h0a00_0002, -1);
    queue_packet(VERSION_V6, 39, 0, 128'h02 << 120, 128'h02 << 120, -1);
    // Multicast boundaries, and the bytes just outside them.
    queue_packet(VERSION_V4, 20, 20, 128'h0a00_0001, 128'he000_0001, -1);
    queue_packet(VERSION_V4, 20, 20, 128'h0a00_0001, 128'hefff_ffff, -1);
    queue_packet(VERSION_V4, 20, 20, 128'h0a00_0001, 128'hdf00_0001, -1);
    queue_packet(VERSION_V4, 20, 20, 128'h0a00_0001, 128'hf000_0001, -1);
    queue_packet(VERSION_V6, 40, 0, 128'h03 << 120, 128'hff02 << 112, -1);
    // Mesh destination but a source from outside the mesh.
    queue_packet(VERSION_V4, 20, 20, 128'h0b00_0001, 128'h0a00_0001, -1);
    queue_packet(VERSION_V4, 20, 20, 128'hc0a9_0001, 128'h0a00_0001, -1);
    // Declared length beyond the bytes received, and below them.
    queue_packet(VERSION_V4, 20, 30, 128'h0a00_0001, 128'h0a00_0002, -1);
    queue_packet(VERSION_V6, 40, 5, 128'h02 << 120, 128'h03 << 120, -1);
    queue_packet(VERSION_V4, 30, 20, 128'h0a00_0001, 128'h0a00_0002, -1);
    drain();

    run_phase(32'h0000_0000, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    run_phase(32'hffff_ffff, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    run_phase($urandom, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1);
    run_phase($urandom, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
    run_phase($urandom, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1);
    run_phase($urandom, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
    run_phase($urandom, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1);
    run_phase($urandom, 1'(($urandom_range(0, 1))), 1'b1, 1'b1, 1'b1, 1'b1);

    // Back-pressure: the receiver holds off while short packets keep coming,
    // so the result queue fills and the input stalls.
    apply_setting($urandom, 1'b1, 1'b1, 1'b1);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    @(negedge clk);
    hold_requests++;
    repeat (20) queue_packet(VERSION_V4, 20, 20, pick_addr(1'b0, ADDR_MESH),
                             pick_addr(1'b0, ADDR_MESH), -1);
    drain();

    $display("Checked %0d packets from %0d bytes under %0d register settings.",
             results_checked, bytes_taken, settings_applied + 1);
    $display("Verdicts: forward %0d, disabled %0d, short %0d, multicast %0d, %s %0d, %s %0d, %s %0d",
             verdict_tally[VERDICT_FORWARD], verdict_tally[VERDICT_DISABLED],
             verdict_tally[VERDICT_SHORT], verdict_tally[VERDICT_MULTICAST],
             "no destination", verdict_tally[VERDICT_NO_DEST],
             "foreign source", verdict_tally[VERDICT_FOREIGN],
             "truncated", verdict_tally[VERDICT_TRUNCATED]);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
